// ----- rtl/core/mi_pkg.sv -----
// Package for the modular inverse unit: word sizes, register map and the
// command/status structs between the controller and the datapath. No dependencies.
package mi_pkg;

    localparam int DATA_BITS  = 32;
    localparam int WORD_BITS  = 32;
    // Coefficient width: Bezout coefficients and partial products stay within 2*modulus.
    localparam int COEF_BITS  = WORD_BITS + 3;
    localparam int CNT_BITS   = $clog2(WORD_BITS);
    localparam int ADDR_BITS  = 3;

    localparam logic [DATA_BITS-1:0] MOD_RESET = 32'd1000000007;
    localparam logic                 REG_MODULUS_SEL = 1'b0;

    typedef struct packed {
        logic load;      // capture operand and modulus, set coefficients
        logic div_init;  // start a quotient/remainder pass
        logic div_step;  // one restoring division bit
        logic update;    // rotate Euclid state with new remainder and coefficient
        logic fold;      // reduce coefficient into 0..modulus-1 and write result
    } mi_cmd_t;

    typedef struct packed {
        logic div_zero;  // divisor has reached zero
    } mi_status_t;

endpackage

// ----- rtl/core/mi_datapath.sv -----
// Datapath of the modular inverse unit: Euclid registers, bit-serial divider
// with coefficient accumulation, and final fold. Depends on mi_pkg.
module mi_datapath import mi_pkg::*; (
    input  logic                 aclk,
    input  mi_cmd_t              cmd,
    input  logic [WORD_BITS-1:0] operand,
    input  logic [WORD_BITS-1:0] modulus,
    output mi_status_t           status,
    output logic [WORD_BITS-1:0] result
);

    logic        [WORD_BITS-1:0] rem_reg, rem_next;
    logic        [WORD_BITS-1:0] div_reg, div_next;
    logic        [WORD_BITS-1:0] mod_reg, mod_next;
    logic        [WORD_BITS-1:0] part_reg, part_next;
    logic        [WORD_BITS-1:0] shr_reg, shr_next;
    logic        [WORD_BITS-1:0] res_reg, res_next;
    logic signed [COEF_BITS-1:0] cu_reg, cu_next;
    logic signed [COEF_BITS-1:0] cv_reg, cv_next;
    logic signed [COEF_BITS-1:0] acc_reg, acc_next;

    logic [WORD_BITS:0]   rsh;
    logic [WORD_BITS:0]   rdiff;
    logic                 ge;
    logic                 cu_neg;
    logic [COEF_BITS-1:0] mag;
    logic [COEF_BITS-1:0] mag_red;
    logic [COEF_BITS-1:0] mod_ext;

    // Shift in the next dividend bit and try a subtract.
    assign rsh   = {part_reg, shr_reg[WORD_BITS-1]};
    assign rdiff = rsh - {1'b0, div_reg};
    assign ge    = !rdiff[WORD_BITS];

    assign cu_neg  = cu_reg[COEF_BITS-1];
    assign mag     = cu_neg ? COEF_BITS'(-cu_reg) : COEF_BITS'(cu_reg);
    assign mod_ext = {{(COEF_BITS-WORD_BITS){1'b0}}, mod_reg};
    assign mag_red = (mag >= mod_ext) ? mag - mod_ext : mag;

    always_comb begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        mod_next  = mod_reg;
        part_next = part_reg;
        shr_next  = shr_reg;
        res_next  = res_reg;
        cu_next   = cu_reg;
        cv_next   = cv_reg;
        acc_next  = acc_reg;
        if (cmd.load) begin
            rem_next = operand;
            div_next = modulus;
            mod_next = modulus;
            cu_next  = COEF_BITS'(1);
            cv_next  = '0;
        end
        if (cmd.div_init) begin
            part_next = '0;
            shr_next  = rem_reg;
            acc_next  = '0;
        end
        if (cmd.div_step) begin
            part_next = ge ? rdiff[WORD_BITS-1:0] : rsh[WORD_BITS-1:0];
            shr_next  = shr_reg << 1;
            // Horner form of q*cv, one quotient bit at a time
            acc_next  = (acc_reg <<< 1) + (ge ? cv_reg : '0);
        end
        if (cmd.update) begin
            rem_next = div_reg;
            div_next = part_reg;
            cu_next  = cv_reg;
            cv_next  = cu_reg - acc_reg;
        end
        if (cmd.fold) begin
            if (mod_reg == '0) begin
                res_next = '0;
            end else if (cu_neg && mag_red != '0) begin
                res_next = mod_reg - mag_red[WORD_BITS-1:0];
            end else begin
                res_next = mag_red[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        mod_reg  <= mod_next;
        part_reg <= part_next;
        shr_reg  <= shr_next;
        res_reg  <= res_next;
        cu_reg   <= cu_next;
        cv_reg   <= cv_next;
        acc_reg  <= acc_next;
    end

    assign status.div_zero = (div_reg == '0);
    assign result          = res_reg;

endmodule

// ----- rtl/core/mi_ctrl.sv -----
// Controller of the modular inverse unit: sequences Euclid iterations and
// the bit-serial divider, owns both handshakes. Depends on mi_pkg.
module mi_ctrl import mi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  mi_status_t status,
    output mi_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_DIV,
        ST_UPD,
        ST_FOLD
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                if (status.div_zero) begin
                    state_next = ST_FOLD;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WORD_BITS - 1)) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_ITER;
            end
            ST_FOLD: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.fold       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/modular_inverse_unit.sv -----
// Top level of the modular inverse unit: APB modulus register, controller
// and datapath. Depends on mi_pkg, mi_ctrl and mi_datapath.
//
// Returns, for each operand transfer, the extended-Euclid Bezout coefficient of
// the operand modulo the programmed modulus, folded into 0..modulus-1 (the true
// inverse when operand and modulus are coprime; 0 for a zero operand or a zero
// modulus). Each Euclid iteration runs the bit-serial restoring divider, which also
// accumulates the quotient times the coefficient; for 32-bit values an item takes
// up to about 47 iterations. One item is processed at a time; a new operand is
// taken while the previous result waits in the output register. The modulus
// resets to 1000000007 and is written at byte address 0; write it only while the
// unit is idle.
module modular_inverse_unit import mi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,   // [31:0] operand
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata,   // [31:0] inverse
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic [DATA_BITS-1:0] modulus_reg, modulus_next;
    logic                 reg_sel;
    mi_cmd_t              cmd;
    mi_status_t           status;
    logic [WORD_BITS-1:0] result;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MODULUS_SEL);
    assign prdata  = reg_sel ? modulus_reg : '0;

    always_comb begin
        modulus_next = modulus_reg;
        if (psel && penable && pwrite && pready && reg_sel) begin
            modulus_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MOD_RESET;
        end else begin
            modulus_reg <= modulus_next;
        end
    end

    mi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .status  (status),
        .cmd     (cmd)
    );

    mi_datapath u_datapath (
        .aclk    (aclk),
        .cmd     (cmd),
        .operand (s_tdata[WORD_BITS-1:0]),
        .modulus (modulus_reg[WORD_BITS-1:0]),
        .status  (status),
        .result  (result)
    );

    assign m_tdata = DATA_BITS'(result);

endmodule

// ----- rtl/core/mi_checker.sv -----
// Port-level checker for the modular inverse unit, bound to the top level.
// Depends on mi_pkg and modular_inverse_unit.
module mi_port_checker import mi_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_BITS-1:0] m_tdata,
    input logic                 pready
);

    // One item at a time: busy right after an operand transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("operand accepted while still busy");

    // Stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // A new result appears only at the end of busy work.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced without an operand in work");

    // Reset clears the output.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind modular_inverse_unit mi_port_checker u_mi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ----- bench/mi_checker.sv -----
// Scoreboard for the modular inverse unit: tracks the modulus register from APB
// writes, predicts each inverse from accepted operands and compares the results.
// Depends on mi_pkg.
module mi_checker import mi_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,   // [31:0] operand
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [DATA_BITS-1:0] m_tdata,   // [31:0] inverse
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output int                   mismatches,
    output int                   pending
);

    typedef struct {
        logic [DATA_BITS-1:0] operand;
        logic [DATA_BITS-1:0] modulus;
        logic [DATA_BITS-1:0] inverse;
    } inverse_entry_t;

    localparam logic [63:0] WORD_MASK = (64'd1 << WORD_BITS) - 64'd1;

    logic [DATA_BITS-1:0] modulus_reg;
    inverse_entry_t       inverse_q[$];
    int                   err_cnt;

    // Extended Euclid with coefficients kept modulo 2^64, then fold into 0..m-1.
    function automatic logic [DATA_BITS-1:0] inverse_mod(input logic [63:0] x,
                                                         input logic [63:0] m);
        logic [63:0] rem, dv, cu, cv, q, r, nu, mag;
        rem = x;
        dv  = m;
        cu  = 64'd1;
        cv  = 64'd0;
        if (m == 64'd0)
            return '0;
        while (dv != 64'd0) begin
            q   = rem / dv;
            r   = rem - q * dv;
            nu  = cu - q * cv;
            rem = dv;
            dv  = r;
            cu  = cv;
            cv  = nu;
        end
        if (cu[63]) begin
            mag = (64'd0 - cu) % m;
            return (mag == 64'd0) ? '0 : DATA_BITS'(m - mag);
        end
        return DATA_BITS'(cu % m);
    endfunction

    always @(posedge aclk) begin
        inverse_entry_t exp_item;
        if (!aresetn) begin
            modulus_reg = MOD_RESET;
            inverse_q.delete();
            err_cnt = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_MODULUS_SEL)
                modulus_reg = pwdata;

            if (s_tvalid && s_tready) begin
                exp_item.operand = s_tdata;
                exp_item.modulus = modulus_reg;
                exp_item.inverse = inverse_mod(64'(s_tdata) & WORD_MASK,
                                               64'(modulus_reg) & WORD_MASK);
                inverse_q.push_back(exp_item);
            end

            if (m_tvalid && m_tready) begin
                if (inverse_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result transfer: inverse %0d", m_tdata);
                end else begin
                    exp_item = inverse_q.pop_front();
                    if (m_tdata !== exp_item.inverse) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("inverse mismatch: operand %0d modulus %0d expected %0d got %0d",
                                     exp_item.operand, exp_item.modulus,
                                     exp_item.inverse, m_tdata);
                    end
                end
            end
        end
        pending    <= inverse_q.size();
        mismatches <= err_cnt;
    end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top for the modular inverse unit: clock, reset, operand and result
// stimulus with APB modulus writes, and the verdict. Depends on mi_pkg,
// mi_checker and modular_inverse_unit.
module tb_top;
    import mi_pkg::*;

    localparam logic [ADDR_BITS-1:0] MODULUS_ADDR = 3'd0;
    localparam logic [ADDR_BITS-1:0] SPARE_ADDR   = 3'd4;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int HOLD_CYCLES  = 6000;
    localparam int TAIL_CYCLES  = 1700;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_BITS-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_BITS-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_BITS-1:0] paddr    = '0;
    logic [DATA_BITS-1:0] pwdata   = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int   mismatches;
    int   pending;
    bit   quiet     = 1'b0;
    bit   hold_req  = 1'b0;
    bit   hold_seen = 1'b0;
    int   hold_left = 0;

    always #5 aclk = ~aclk;

    modular_inverse_unit dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    mi_checker checker_i (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .mismatches, .pending
    );

    // Result side: random back-pressure, with one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 7);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL modular_inverse_unit");
        $finish;
    end

    task automatic push_operand(input logic [DATA_BITS-1:0] value);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        if (!quiet && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Wait until every expected inverse has been transferred.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [ADDR_BITS-1:0] addr,
                             input logic [DATA_BITS-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [DATA_BITS-1:0] pick_operand(input logic [DATA_BITS-1:0] m);
        int   sel;
        int   f;
        sel = $urandom_range(99);
        if (sel < 55)
            return $urandom;
        if (sel < 70)
            return $urandom_range(0, 64);
        if (sel < 85)
            return m + $urandom_range(0, 8) - 4;
        // share a small factor with the modulus where one exists
        for (f = 2; f <= 16; f++) begin
            if (m % f == 0)
                return f * $urandom_range(1, 32'hFFFFFFFF / f);
        end
        return $urandom;
    endfunction

    task automatic run_phase(input logic [DATA_BITS-1:0] m, input int count,
                             input bit calm, input bit squeeze);
        int i;
        apb_write(MODULUS_ADDR, m);
        quiet = calm;
        for (i = 0; i < count; i++) begin
            if (squeeze && i == 8)
                hold_req = ~hold_req;
            push_operand(pick_operand(m));
        end
        drain();
        quiet = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset modulus is the prime 1000000007
        push_operand(32'd0);
        push_operand(32'd1);
        push_operand(32'd2);
        push_operand(32'd1000000006);
        push_operand(32'd1000000007);
        push_operand(32'd1000000008);
        push_operand(32'hFFFFFFFF);
        push_operand(32'h80000000);
        push_operand(32'h55555555);
        push_operand(32'hAAAAAAAA);

        // composite modulus: operands sharing factors
        apb_write(MODULUS_ADDR, 32'd720720);
        push_operand(32'd360360);
        push_operand(32'd1001);
        push_operand(32'd720719);
        push_operand(32'd0);

        apb_write(MODULUS_ADDR, 32'd1);
        push_operand(32'd7);
        apb_write(MODULUS_ADDR, 32'd0);
        push_operand(32'd5);
        apb_write(MODULUS_ADDR, 32'd2);
        push_operand(32'd1);
        push_operand(32'd3);
        // write outside the register map: modulus must stay at 2
        apb_write(SPARE_ADDR, 32'd12345);
        push_operand(32'd3);
        apb_write(MODULUS_ADDR, 32'hFFFFFFFF);
        push_operand(32'hFFFFFFFE);

        run_phase(32'd2,        20, 1'b0, 1'b0);
        run_phase(32'hFFFFFFFF, 60, 1'b0, 1'b0);
        run_phase(32'hFFFFFFFB, 60, 1'b1, 1'b0);
        run_phase($urandom_range(2, 32'hFFFFFFFF), 60, 1'b0, 1'b1);
        run_phase(32'd720720,   40, 1'b0, 1'b0);
        run_phase(32'h80000000, 40, 1'b0, 1'b0);
        run_phase($urandom_range(2, 32'hFFFFFFFF), 50, 1'b0, 1'b0);
        run_phase(32'd1000000007, 40, 1'b0, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("PASS modular_inverse_unit");
        else
            $display("FAIL modular_inverse_unit");
        $finish;
    end

endmodule
